@@ design/assert_macros.svh @@
// assertion macros shared by the byte pipe manager
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define MCBP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define MCBP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ design/mcbp_pkg.sv @@
`timescale 1ns / 1ps
// types and codes for the multi-channel byte pipe manager
// no dependencies; used by the channel interfaces and the top level
package mcbp_pkg;

    // operation codes of an input word
    typedef enum logic [1:0] {
        FN_CREATE = 2'd0,
        FN_READ   = 2'd1,
        FN_WRITE  = 2'd2,
        FN_CLOSE  = 2'd3
    } t_func;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_DESC    = 3'd1,
        ST_WRONG_END   = 3'd2,
        ST_WOULD_BLOCK = 3'd3,
        ST_EOS         = 3'd4,
        ST_BROKEN      = 3'd5,
        ST_NO_RES      = 3'd6
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_PREAD,
        S_BREAD,
        S_DONE
    } t_state;

    localparam int DESC_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int FUNC_W      = 2;
    localparam logic [DESC_W-1:0] DESC_BASE_RST = 16'd200;

endpackage

@@ design/mcbp_if.sv @@
`timescale 1ns / 1ps
// valid/ready channel interfaces for request and result words
// depends on mcbp_pkg for field widths
interface mcbp_in_if;
    logic                            valid;
    logic                            ready;
    logic [mcbp_pkg::FUNC_W-1:0]     func;
    logic [mcbp_pkg::DESC_W-1:0]     descriptor;
    logic [mcbp_pkg::BYTE_W-1:0]     write_data;
    logic                            final_byte;

    modport source (output valid, func, descriptor, write_data, final_byte, input ready);
    modport sink   (input valid, func, descriptor, write_data, final_byte, output ready);
endinterface

interface mcbp_out_if;
    logic                            valid;
    logic                            ready;
    logic [mcbp_pkg::STATUS_W-1:0]   status;
    logic [mcbp_pkg::BYTE_W-1:0]     read_data;
    logic [mcbp_pkg::DESC_W-1:0]     new_read_descriptor;
    logic [mcbp_pkg::DESC_W-1:0]     new_write_descriptor;
    logic                            transfer_end;

    modport source (output valid, status, read_data, new_read_descriptor,
                    new_write_descriptor, transfer_end, input ready);
    modport sink   (input valid, status, read_data, new_read_descriptor,
                    new_write_descriptor, transfer_end, output ready);
endinterface

@@ design/multi_channel_byte_pipe_manager.sv @@
`timescale 1ns / 1ps
// Byte pipe pool with descriptor table; one request word in flight at a time.
// Each word passes lookup (create and a bad descriptor finish there), then the
// pipe-state memory read (write, close, status-only read), then the byte store
// read for a read that returns a byte; a held result stalls it in the done state.
// Synchronous active-low reset clears the busy maps, sequencer and output valid
// flag and loads the descriptor base; no clearing pass, ready right after reset.
`include "assert_macros.svh"

module multi_channel_byte_pipe_manager #(
    parameter int PIPE_COUNT = 16,
    parameter int PIPE_DEPTH = 4096,
    parameter int SLOT_COUNT = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mcbp_pkg::DESC_W-1:0]   i_cfg_wdata,
    mcbp_in_if.sink                       i_in,
    mcbp_out_if.source                    o_out
);

    localparam int PW       = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1;
    localparam int SW       = $clog2(SLOT_COUNT);
    localparam int PTR_W    = $clog2(PIPE_DEPTH);
    localparam int FILL_W   = $clog2(PIPE_DEPTH + 1);
    localparam int MEM_SIZE = PIPE_COUNT * PIPE_DEPTH;
    localparam int ADDR_W   = $clog2(MEM_SIZE);
    localparam int DW       = mcbp_pkg::DESC_W;
    localparam int BW       = mcbp_pkg::BYTE_W;

    // one pipe-state record
    typedef struct packed {
        logic [PTR_W-1:0]  head;
        logic [PTR_W-1:0]  tail;
        logic [FILL_W-1:0] fill;
        logic              ropen;
        logic              wopen;
    } t_pipe_rec;

    // memories
    logic [BW-1:0] byte_mem [MEM_SIZE];
    t_pipe_rec     pipe_mem [PIPE_COUNT];

    // control and payload registers
    mcbp_pkg::t_state   r_state, n_state;
    logic [DW-1:0]      r_desc_base;
    mcbp_pkg::t_func    r_func;
    logic [DW-1:0]      r_desc;
    logic [BW-1:0]      r_wdata;
    logic               r_fin;
    logic [PIPE_COUNT-1:0] r_pipe_busy, n_pipe_busy;
    logic [SLOT_COUNT-1:0] r_slot_busy, n_slot_busy;
    logic [PW-1:0]      r_slot_pipe [SLOT_COUNT];
    logic               r_slot_is_wr [SLOT_COUNT];
    logic [SW-1:0]      r_slot;
    logic [PW-1:0]      r_pipe;
    logic               r_is_wr;
    logic [ADDR_W-1:0]  r_pipe_base;
    t_pipe_rec          r_prec_q;
    logic [BW-1:0]      r_byte_q;

    // result being assembled
    mcbp_pkg::t_status  r_status, n_status;
    logic [BW-1:0]      r_rdata, n_rdata;
    logic [DW-1:0]      r_rdesc, n_rdesc;
    logic [DW-1:0]      r_wdesc, n_wdesc;

    // output register
    logic               r_out_valid;
    mcbp_pkg::t_status  r_out_status;
    logic [BW-1:0]      r_out_rdata;
    logic [DW-1:0]      r_out_rdesc;
    logic [DW-1:0]      r_out_wdesc;
    logic               r_out_end;

    // combinational control
    logic               accept;
    logic               out_load;
    logic               pipe_found, r_found, w_found, create_ok;
    logic [PW-1:0]      free_pipe;
    logic [SW-1:0]      free_r, free_w;
    logic [DW:0]        desc_off;
    logic [SW-1:0]      slot_idx;
    logic               slot_ok;
    logic               slot_tab_we;
    logic               prec_we;
    logic [PW-1:0]      prec_waddr;
    t_pipe_rec          prec_wdata;
    logic               byte_re, byte_we;
    logic [ADDR_W-1:0]  byte_addr;
    logic [PTR_W-1:0]   head_adv, tail_adv;
    logic               close_ropen, close_wopen;

    assign accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == mcbp_pkg::S_IDLE);

    // lowest free pipe
    always_comb begin
        pipe_found = 1'b0;
        free_pipe  = '0;
        for (int i = PIPE_COUNT - 1; i >= 0; i--) begin
            if (!r_pipe_busy[i]) begin
                pipe_found = 1'b1;
                free_pipe  = PW'(i);
            end
        end
    end

    // two lowest free slots, lower one is the read end
    always_comb begin
        r_found = 1'b0;
        w_found = 1'b0;
        free_r  = '0;
        free_w  = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!r_slot_busy[i]) begin
                if (!r_found) begin
                    r_found = 1'b1;
                    free_r  = SW'(i);
                end else if (!w_found) begin
                    w_found = 1'b1;
                    free_w  = SW'(i);
                end
            end
        end
    end

    assign create_ok = pipe_found && r_found && w_found;

    // descriptor lookup on full 16-bit values
    assign desc_off = {1'b0, r_desc} - {1'b0, r_desc_base};
    assign slot_idx = desc_off[SW-1:0];
    assign slot_ok  = !desc_off[DW] && (desc_off[DW-1:0] < DW'(SLOT_COUNT))
                      && r_slot_busy[slot_idx];

    // ring pointer advance
    assign head_adv = (r_prec_q.head == PTR_W'(PIPE_DEPTH - 1)) ? '0 : r_prec_q.head + 1'b1;
    assign tail_adv = (r_prec_q.tail == PTR_W'(PIPE_DEPTH - 1)) ? '0 : r_prec_q.tail + 1'b1;
    assign close_ropen = r_is_wr ? r_prec_q.ropen : 1'b0;
    assign close_wopen = r_is_wr ? 1'b0 : r_prec_q.wopen;

    assign byte_addr = r_pipe_base + ADDR_W'((r_func == mcbp_pkg::FN_WRITE) ?
                                             r_prec_q.tail : r_prec_q.head);

    // sequencer next state and strobes
    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_rdata     = r_rdata;
        n_rdesc     = r_rdesc;
        n_wdesc     = r_wdesc;
        n_pipe_busy = r_pipe_busy;
        n_slot_busy = r_slot_busy;
        slot_tab_we = 1'b0;
        prec_we     = 1'b0;
        prec_waddr  = r_pipe;
        prec_wdata  = r_prec_q;
        byte_re     = 1'b0;
        byte_we     = 1'b0;
        out_load    = 1'b0;
        case (r_state)
            mcbp_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = mcbp_pkg::S_LOOKUP;
                end
            end
            mcbp_pkg::S_LOOKUP: begin
                n_status = mcbp_pkg::ST_OK;
                n_rdata  = '0;
                n_rdesc  = '0;
                n_wdesc  = '0;
                n_state  = mcbp_pkg::S_DONE;
                if (r_func == mcbp_pkg::FN_CREATE) begin
                    if (!create_ok) begin
                        n_status = mcbp_pkg::ST_NO_RES;
                    end else begin
                        n_pipe_busy[free_pipe] = 1'b1;
                        n_slot_busy[free_r]    = 1'b1;
                        n_slot_busy[free_w]    = 1'b1;
                        slot_tab_we            = 1'b1;
                        prec_we                = 1'b1;
                        prec_waddr             = free_pipe;
                        prec_wdata             = '{head: '0, tail: '0, fill: '0,
                                                   ropen: 1'b1, wopen: 1'b1};
                        n_rdesc = r_desc_base + DW'(free_r);
                        n_wdesc = r_desc_base + DW'(free_w);
                    end
                end else if (!slot_ok) begin
                    n_status = mcbp_pkg::ST_BAD_DESC;
                end else begin
                    n_state = mcbp_pkg::S_PREAD;
                end
            end
            mcbp_pkg::S_PREAD: begin
                n_state = mcbp_pkg::S_DONE;
                case (r_func)
                    mcbp_pkg::FN_READ: begin
                        if (r_is_wr) begin
                            n_status = mcbp_pkg::ST_WRONG_END;
                        end else if (r_prec_q.fill == '0) begin
                            n_status = r_prec_q.wopen ? mcbp_pkg::ST_WOULD_BLOCK
                                                      : mcbp_pkg::ST_EOS;
                        end else begin
                            byte_re         = 1'b1;
                            prec_we         = 1'b1;
                            prec_wdata.head = head_adv;
                            prec_wdata.fill = r_prec_q.fill - 1'b1;
                            n_state         = mcbp_pkg::S_BREAD;
                        end
                    end
                    mcbp_pkg::FN_WRITE: begin
                        if (!r_is_wr) begin
                            n_status = mcbp_pkg::ST_WRONG_END;
                        end else if (!r_prec_q.ropen) begin
                            n_status = mcbp_pkg::ST_BROKEN;
                        end else if (r_prec_q.fill == FILL_W'(PIPE_DEPTH)) begin
                            n_status = mcbp_pkg::ST_WOULD_BLOCK;
                        end else begin
                            byte_we         = 1'b1;
                            prec_we         = 1'b1;
                            prec_wdata.tail = tail_adv;
                            prec_wdata.fill = r_prec_q.fill + 1'b1;
                        end
                    end
                    mcbp_pkg::FN_CLOSE: begin
                        prec_we              = 1'b1;
                        prec_wdata.ropen     = close_ropen;
                        prec_wdata.wopen     = close_wopen;
                        n_slot_busy[r_slot]  = 1'b0;
                        if (!close_ropen && !close_wopen) begin
                            n_pipe_busy[r_pipe] = 1'b0;
                        end
                    end
                    default: begin
                        n_state = mcbp_pkg::S_DONE;
                    end
                endcase
            end
            mcbp_pkg::S_BREAD: begin
                n_rdata = r_byte_q;
                n_state = mcbp_pkg::S_DONE;
            end
            mcbp_pkg::S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = mcbp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mcbp_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mcbp_pkg::S_IDLE;
            r_desc_base <= mcbp_pkg::DESC_BASE_RST;
            r_pipe_busy <= '0;
            r_slot_busy <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pipe_busy <= n_pipe_busy;
            r_slot_busy <= n_slot_busy;
            if (i_cfg_we) begin
                r_desc_base <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture and result assembly
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= mcbp_pkg::t_func'(i_in.func);
            r_desc  <= i_in.descriptor;
            r_wdata <= i_in.write_data;
            r_fin   <= i_in.final_byte;
        end
        r_status <= n_status;
        r_rdata  <= n_rdata;
        r_rdesc  <= n_rdesc;
        r_wdesc  <= n_wdesc;
        if (r_state == mcbp_pkg::S_LOOKUP) begin
            r_slot      <= slot_idx;
            r_pipe      <= r_slot_pipe[slot_idx];
            r_is_wr     <= r_slot_is_wr[slot_idx];
            r_pipe_base <= ADDR_W'(r_slot_pipe[slot_idx]) * ADDR_W'(PIPE_DEPTH);
        end
        if (out_load) begin
            r_out_status <= r_status;
            r_out_rdata  <= r_rdata;
            r_out_rdesc  <= r_rdesc;
            r_out_wdesc  <= r_wdesc;
            r_out_end    <= r_fin;
        end
    end

    // descriptor slot table
    always_ff @(posedge i_clk) begin
        if (slot_tab_we) begin
            r_slot_pipe[free_r]  <= free_pipe;
            r_slot_is_wr[free_r] <= 1'b0;
            r_slot_pipe[free_w]  <= free_pipe;
            r_slot_is_wr[free_w] <= 1'b1;
        end
    end

    // pipe-state memory, one read and one write port
    always_ff @(posedge i_clk) begin
        if (prec_we) begin
            pipe_mem[prec_waddr] <= prec_wdata;
        end
        if (r_state == mcbp_pkg::S_LOOKUP) begin
            r_prec_q <= pipe_mem[r_slot_pipe[slot_idx]];
        end
    end

    // byte store, one shared address port
    always_ff @(posedge i_clk) begin
        if (byte_we) begin
            byte_mem[byte_addr] <= r_wdata;
        end
        if (byte_re) begin
            r_byte_q <= byte_mem[byte_addr];
        end
    end

    // result channel
    assign o_out.valid                = r_out_valid;
    assign o_out.status               = r_out_status;
    assign o_out.read_data            = r_out_rdata;
    assign o_out.new_read_descriptor  = r_out_rdesc;
    assign o_out.new_write_descriptor = r_out_wdesc;
    assign o_out.transfer_end         = r_out_end;

    // checks
    `MCBP_ASSERT(a_create_takes_two, i_clk, i_rst_n, (r_state == mcbp_pkg::S_LOOKUP && r_func == mcbp_pkg::FN_CREATE && create_ok) |=> ($countones(r_slot_busy) == $past($countones(r_slot_busy)) + 2), "create did not claim two slots")
    `MCBP_ASSERT(a_close_frees_one, i_clk, i_rst_n, (r_state == mcbp_pkg::S_PREAD && r_func == mcbp_pkg::FN_CLOSE) |=> ($countones(r_slot_busy) + 1 == $past($countones(r_slot_busy))), "close did not free one slot")
    `MCBP_ASSERT(a_read_nonempty, i_clk, i_rst_n, byte_re |-> (r_prec_q.fill != '0 && r_state == mcbp_pkg::S_PREAD), "byte read from an empty pipe")
    `MCBP_ASSERT(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == mcbp_pkg::S_DONE), "result shown without finished word")
    `MCBP_ASSERT_NEVER(a_no_mem_collide, i_clk, i_rst_n, byte_re && byte_we, "byte store read and write together")

endmodule
